FILE: rtl/bqdr_pkg.sv
// Shared constants, types and ring-address helper for the byte queue.
`timescale 1ns / 1ps

package bqdr_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = AW + 1;
  localparam int FILL_W = 7;
  localparam int SEEN_N = 256;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_DEDUP = 2'd2;
  localparam logic [1:0] OP_REV   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [7:0]    byte_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic  we;
    byte_t waddr;
    logic  wdata;
    logic  re;
    byte_t raddr;
  } seen_req_t;

  typedef struct packed {
    logic              vld;
    byte_t             pop_value;
    logic              pop_valid;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill_level;
  } res_t;

  // (head + off) mod DEPTH, with off < DEPTH
  function automatic addr_t ring_pos(addr_t head, cnt_t off);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

FILE: rtl/bqdr_ram.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module bqdr_ram (
  input  logic                clk,
  input  bqdr_pkg::ram_req_t  req,
  output bqdr_pkg::byte_t     rdata
);
  import bqdr_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bqdr_seen.sv
// Seen-value map for dedup: one bit per byte value, one write port, registered read.
`timescale 1ns / 1ps

module bqdr_seen (
  input  logic                 clk,
  input  bqdr_pkg::seen_req_t  req,
  output logic                 hit
);
  import bqdr_pkg::*;

  logic mem [SEEN_N];
  logic hit_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      hit_r <= mem[req.raddr];
    end
  end

  assign hit = hit_r;

endmodule

FILE: rtl/bqdr_ctrl.sv
// Queue sequencer: push/pop, dedup walk and reverse swap loop over the entry store.
`timescale 1ns / 1ps

module bqdr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  input  bqdr_pkg::byte_t      in_value,
  output logic                 in_stall,
  input  logic                 out_free,
  output bqdr_pkg::ram_req_t   ram_req,
  input  bqdr_pkg::byte_t      ram_rdata,
  output bqdr_pkg::seen_req_t  seen_req,
  input  logic                 seen_hit,
  output bqdr_pkg::res_t       res
);
  import bqdr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_DD_RD  = 4'd2;
  localparam logic [3:0] S_DD_LK  = 4'd3;
  localparam logic [3:0] S_DD_WR  = 4'd4;
  localparam logic [3:0] S_DC     = 4'd5;
  localparam logic [3:0] S_RV_RLO = 4'd6;
  localparam logic [3:0] S_RV_RHI = 4'd7;
  localparam logic [3:0] S_RV_WLO = 4'd8;
  localparam logic [3:0] S_RV_WHI = 4'd9;
  localparam logic [3:0] S_RES    = 4'd10;

  logic [3:0] state_r, state_nxt;
  addr_t      head_r, head_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       rd_r, rd_nxt;     // dedup read offset / reverse low offset
  cnt_t       wr_r, wr_nxt;     // dedup write offset / reverse high offset
  logic       pv_r, pv_nxt;     // read data in flight during seen-map cleanup
  logic       popok_r, popok_nxt;
  byte_t      tmp_r, tmp_nxt;
  byte_t      clr_r, clr_nxt;   // seen-map clear address after reset

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    pv_nxt       = 1'b0;
    popok_nxt    = popok_r;
    tmp_nxt      = tmp_r;
    clr_nxt      = clr_r;
    ram_req      = '0;
    seen_req     = '0;
    res          = '0;
    in_stall     = 1'b1;

    case (state_r)
      S_CLR: begin
        seen_req.we    = 1'b1;
        seen_req.waddr = clr_r;
        seen_req.wdata = 1'b0;
        clr_nxt        = clr_r + byte_t'(1);
        if (clr_r == byte_t'(SEEN_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          case (in_op)
            OP_PUSH: begin
              res.vld = 1'b1;
              if (count_r < cnt_t'(DEPTH)) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ring_pos(head_r, count_r);
                ram_req.wdata = in_value;
                count_nxt     = count_r + cnt_t'(1);
                res.status    = ST_OK;
              end else begin
                res.status = ST_FULL;
              end
              res.fill_level = FILL_W'(count_nxt);
            end
            OP_POP: begin
              if (count_r == '0) begin
                res.vld        = 1'b1;
                res.status     = ST_EMPTY;
                res.fill_level = FILL_W'(count_r);
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = head_r;
                head_nxt      = ring_pos(head_r, cnt_t'(1));
                count_nxt     = count_r - cnt_t'(1);
                popok_nxt     = 1'b1;
                state_nxt     = S_RES;
              end
            end
            OP_DEDUP: begin
              rd_nxt       = '0;
              wr_nxt       = '0;
              popok_nxt    = 1'b0;
              state_nxt    = S_DD_RD;
            end
            default: begin
              popok_nxt = 1'b0;
              if (count_r < cnt_t'(2)) begin
                state_nxt = S_RES;
              end else begin
                rd_nxt    = '0;
                wr_nxt    = count_r - cnt_t'(1);
                state_nxt = S_RV_RLO;
              end
            end
          endcase
        end
      end

      S_DD_RD: begin
        if (rd_r == count_r) begin
          count_nxt = wr_r;
          rd_nxt    = '0;
          state_nxt = S_DC;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ring_pos(head_r, rd_r);
          rd_nxt        = rd_r + cnt_t'(1);
          state_nxt     = S_DD_LK;
        end
      end

      S_DD_LK: begin
        seen_req.re    = 1'b1;
        seen_req.raddr = ram_rdata;
        state_nxt      = S_DD_WR;
      end

      S_DD_WR: begin
        if (!seen_hit) begin
          ram_req.we     = 1'b1;
          ram_req.waddr  = ring_pos(head_r, wr_r);
          ram_req.wdata  = ram_rdata;
          seen_req.we    = 1'b1;
          seen_req.waddr = ram_rdata;
          seen_req.wdata = 1'b1;
          wr_nxt         = wr_r + cnt_t'(1);
        end
        state_nxt = S_DD_RD;
      end

      // kept entries hold exactly the set bits: clear them for the next dedup
      S_DC: begin
        if (rd_r != count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ring_pos(head_r, rd_r);
          rd_nxt        = rd_r + cnt_t'(1);
          pv_nxt        = 1'b1;
        end
        if (pv_r) begin
          seen_req.we    = 1'b1;
          seen_req.waddr = ram_rdata;
          seen_req.wdata = 1'b0;
        end else if (rd_r == count_r) begin
          state_nxt = S_RES;
        end
      end

      S_RV_RLO: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ring_pos(head_r, rd_r);
        state_nxt     = S_RV_RHI;
      end

      S_RV_RHI: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ring_pos(head_r, wr_r);
        tmp_nxt       = ram_rdata;
        state_nxt     = S_RV_WLO;
      end

      S_RV_WLO: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ring_pos(head_r, rd_r);
        ram_req.wdata = ram_rdata;
        state_nxt     = S_RV_WHI;
      end

      S_RV_WHI: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ring_pos(head_r, wr_r);
        ram_req.wdata = tmp_r;
        rd_nxt        = rd_r + cnt_t'(1);
        wr_nxt        = wr_r - cnt_t'(1);
        if (rd_nxt < wr_nxt) begin
          state_nxt = S_RV_RLO;
        end else begin
          state_nxt = S_RES;
        end
      end

      S_RES: begin
        res.vld        = 1'b1;
        res.pop_valid  = popok_r;
        res.pop_value  = popok_r ? ram_rdata : '0;
        res.status     = ST_OK;
        res.fill_level = FILL_W'(count_r);
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      head_r  <= '0;
      count_r <= '0;
      pv_r    <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pv_r    <= pv_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    popok_r <= popok_nxt;
    tmp_r   <= tmp_nxt;
  end

endmodule

FILE: rtl/byte_queue_dedup_reverse_top.sv
// Top level of the byte queue with dedup and reverse: sequencer, stores, result register.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_op, in_value
//   out_     output     out_valid/out_stall out_pop_value, out_pop_valid, out_status,
//                                           out_fill_level
//
// Push and failing pop answer straight from idle; pop with data passes through a result
// state for the registered entry store read. Dedup: each entry takes a store read, a
// seen-map read and, if kept, a write-back, then the kept entries' seen bits are
// cleared one per cycle. Reverse: each swapped pair takes two store reads and two
// writes, bound by the store's single read port and single write port.
// Reset is synchronous; the entry store is not cleared, the seen map is cleared by a
// pass over all 256 entries right after reset, with the input stalled.
// Input is stalled while an operation runs or the result register is full and stalled.
`timescale 1ns / 1ps

module byte_queue_dedup_reverse_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic [7:0]                           in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_pop_value,
  output logic                                 out_pop_valid,
  output logic [1:0]                           out_status,
  output logic [bqdr_pkg::FILL_W-1:0]          out_fill_level
);
  import bqdr_pkg::*;

  ram_req_t  ram_req;
  byte_t     ram_rdata;
  seen_req_t seen_req;
  logic      seen_hit;
  res_t      res;
  logic      out_free;

  logic              out_valid_r, out_valid_nxt;
  byte_t             pop_value_r;
  logic              pop_valid_r;
  logic [1:0]        status_r;
  logic [FILL_W-1:0] fill_level_r;

  assign out_free = !out_valid_r || !out_stall;

  bqdr_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  bqdr_seen u_seen (
    .clk   (clk),
    .req   (seen_req),
    .hit   (seen_hit)
  );

  bqdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_value  (in_value),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .seen_req  (seen_req),
    .seen_hit  (seen_hit),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && out_free) begin
      pop_value_r  <= res.pop_value;
      pop_valid_r  <= res.pop_valid;
      status_r     <= res.status;
      fill_level_r <= res.fill_level;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pop_value  = pop_value_r;
  assign out_pop_valid  = pop_valid_r;
  assign out_status     = status_r;
  assign out_fill_level = fill_level_r;

endmodule
